// ===== rtl/core/salpd_pkg.sv =====
`default_nettype none

package salpd_pkg;

    localparam int DEF_MAX_PACKET_BYTES = 32;
    localparam int DEF_MIN_PACKET_BYTES = 7;
    localparam int DEF_LENGTH_POSITION  = 5;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET     = 8'hAE;
    localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE     = 2'd1;

    // hand-off from the parser to the read-out sequencer
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] len;
    } emit_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/salpd_ram.sv =====
`default_nettype none

module salpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/salpd_parser.sv =====
`default_nettype none

module salpd_parser #(
    parameter int MAX_PACKET_BYTES = 32,
    parameter int MIN_PACKET_BYTES = 7,
    parameter int LENGTH_POSITION  = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic [salpd_pkg::BYTE_W-1:0]        rx_byte,
    input  wire logic [salpd_pkg::BYTE_W-1:0]        device_address,
    input  wire logic [salpd_pkg::BYTE_W-1:0]        sync_value,
    output logic                                     wr_en,
    output logic [$clog2(MAX_PACKET_BYTES)-1:0]      wr_addr,
    output logic [salpd_pkg::BYTE_W-1:0]             wr_data,
    output salpd_pkg::emit_req_t                     emit_req
);

    import salpd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
    localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0]  HDR_CNT  = CNT_W'(LENGTH_POSITION + 1);
    localparam logic [BYTE_W-1:0] LEN_MIN  = BYTE_W'(MIN_PACKET_BYTES);
    localparam logic [BYTE_W-1:0] LEN_HDR  = BYTE_W'(LENGTH_POSITION + 1);
    localparam logic [BYTE_W-1:0] LEN_MAX  = BYTE_W'(MAX_PACKET_BYTES);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ADDR,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] decl_len_reg, decl_len_next;
    logic [CNT_W-1:0]  stored_count;
    logic              has_room;
    logic              len_ok;

    assign has_room     = byte_count_reg < MAX_CNT;
    assign stored_count = has_room ? byte_count_reg + CNT_W'(1) : byte_count_reg;
    assign len_ok       = (rx_byte >= LEN_MIN) && (rx_byte >= LEN_HDR) && (rx_byte <= LEN_MAX);

    assign wr_addr = byte_count_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        decl_len_next   = decl_len_reg;
        wr_en           = 1'b0;
        emit_req.start  = 1'b0;
        emit_req.len    = decl_len_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC2, PH_ADDR:
                begin
                    if (rx_byte == ((phase_reg == PH_SYNC2) ? sync_value : device_address))
                    begin
                        wr_en           = has_room;
                        byte_count_next = stored_count;
                        phase_next      = (phase_reg == PH_SYNC2) ? PH_ADDR : PH_HEADER;
                    end
                    else
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_SYNC1;
                    end
                end
                PH_HEADER:
                begin
                    wr_en           = has_room;
                    byte_count_next = stored_count;
                    // the length byte is the one arriving now
                    if (stored_count == HDR_CNT)
                    begin
                        if (len_ok)
                        begin
                            decl_len_next = rx_byte;
                            if (rx_byte == BYTE_W'(stored_count))
                            begin
                                emit_req.start  = 1'b1;
                                emit_req.len    = rx_byte;
                                byte_count_next = '0;
                                phase_next      = PH_SYNC1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        else
                        begin
                            byte_count_next = '0;
                            phase_next      = PH_SYNC1;
                        end
                    end
                end
                PH_BODY:
                begin
                    wr_en           = has_room;
                    byte_count_next = stored_count;
                    if (BYTE_W'(stored_count) >= decl_len_reg)
                    begin
                        emit_req.start  = 1'b1;
                        emit_req.len    = BYTE_W'(stored_count);
                        byte_count_next = '0;
                        phase_next      = PH_SYNC1;
                    end
                end
                default:
                begin
                    byte_count_next = '0;
                    phase_next      = PH_SYNC1;
                    if (rx_byte == sync_value)
                    begin
                        wr_en           = 1'b1;
                        byte_count_next = CNT_W'(1);
                        phase_next      = PH_SYNC2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            byte_count_reg <= '0;
            decl_len_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            decl_len_reg   <= decl_len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/salpd_emitter.sv =====
`default_nettype none

module salpd_emitter #(
    parameter int MAX_PACKET_BYTES = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire salpd_pkg::emit_req_t                emit_req,
    output logic                                     busy,
    output logic                                     rd_en,
    output logic [$clog2(MAX_PACKET_BYTES)-1:0]      rd_addr,
    input  wire logic [salpd_pkg::BYTE_W-1:0]        rd_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [salpd_pkg::BYTE_W-1:0]             packet_byte,
    output logic [salpd_pkg::POS_W-1:0]              byte_position,
    output logic                                     last_byte
);

    import salpd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
    localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              pend_reg, pend_next;
    logic [POS_W-1:0]  pend_pos_reg, pend_pos_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;
    logic              load;
    logic              issue;
    logic [CNT_W-1:0]  addr_inc;

    // RAM read data waits in the RAM output until the output register frees up
    assign load     = pend_reg && (!out_valid_reg || out_ready);
    assign issue    = busy_reg && (!pend_reg || load);
    assign addr_inc = addr_reg + CNT_W'(1);

    assign rd_en   = issue;
    assign rd_addr = addr_reg[ADDR_W-1:0];

    always_comb
    begin
        busy_next      = busy_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            out_pos_next   = pend_pos_reg;
            out_last_next  = pend_last_reg;
            pend_next      = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            pend_next      = 1'b1;
            pend_pos_next  = POS_W'(addr_reg);
            pend_last_next = (addr_inc == len_reg);
            addr_next      = addr_inc;
            if (addr_inc == len_reg)
            begin
                busy_next = 1'b0;
            end
        end

        if (emit_req.start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
            len_next  = CNT_W'(emit_req.len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            addr_reg      <= '0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            addr_reg      <= addr_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg  <= pend_pos_next;
        pend_last_reg <= pend_last_next;
        out_byte_reg  <= out_byte_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign busy          = busy_reg;
    assign out_valid     = out_valid_reg;
    assign packet_byte   = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign last_byte     = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sync_address_length_packet_deframer.sv =====
`default_nettype none

// Packet deframer: takes one received byte per item, hunts for two sync bytes
// and the device address, gathers the header up to the length byte and then
// the body into a packet RAM. A received byte is taken whenever no packet is
// being read out. When the last byte of a valid packet arrives, input is held
// off while the packet is read out of the RAM, one byte per cycle while
// out_ready stays high (one RAM read port), so input stays blocked until every
// byte has been read from the RAM, longer if the output stalls; each byte leaves
// through the RAM read register and then the output register. Registers: index
// 0 device_address, index 1 sync_value; write them only while the block is idle.

module sync_address_length_packet_deframer #(
    parameter int MAX_PACKET_BYTES = salpd_pkg::DEF_MAX_PACKET_BYTES,
    parameter int MIN_PACKET_BYTES = salpd_pkg::DEF_MIN_PACKET_BYTES,
    parameter int LENGTH_POSITION  = salpd_pkg::DEF_LENGTH_POSITION
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [salpd_pkg::BYTE_W-1:0]       rx_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [salpd_pkg::BYTE_W-1:0]            packet_byte,
    output logic [salpd_pkg::POS_W-1:0]             byte_position,
    output logic                                    last_byte,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [salpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [salpd_pkg::BYTE_W-1:0]       cfg_data
);

    import salpd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);

    logic [BYTE_W-1:0] device_address_reg;
    logic [BYTE_W-1:0] sync_value_reg;
    logic              accept;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    emit_req_t         emit_req;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            sync_value_reg     <= SYNC_VALUE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                REG_SYNC_VALUE:     sync_value_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    salpd_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .MIN_PACKET_BYTES (MIN_PACKET_BYTES),
        .LENGTH_POSITION  (LENGTH_POSITION)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .device_address (device_address_reg),
        .sync_value     (sync_value_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .emit_req       (emit_req)
    );

    salpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PACKET_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    salpd_emitter #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit_req      (emit_req),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_byte   (packet_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte)
    );

endmodule

`default_nettype wire
